// ===== src/sdsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsh_pkg: shared types and constants for the SD SPI host sequencer
// Holds the input/result payload types, opcode and phase codes, error codes.
// ----------------------------------------------------------------------------
package sdsh_pkg;

	localparam int BLOCK_BYTES_DEF = 512;
	localparam int FIFO_DEPTH      = 2;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_READ = 2'd1,
		OP_BYTE = 2'd2,
		OP_TICK = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_PRE, PH_BUSY, PH_FRAME, PH_RESP, PH_R7, PH_OCR,
		PH_GAP, PH_TOKEN, PH_DATA, PH_CRC, PH_RELEASE
	} phase_t;

	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_IDLE     = 4'd1;
	localparam logic [3:0] ERR_PATTERN  = 4'd2;
	localparam logic [3:0] ERR_IFCOND   = 4'd3;
	localparam logic [3:0] ERR_OPCOND   = 4'd4;
	localparam logic [3:0] ERR_OPC_TO   = 4'd5;
	localparam logic [3:0] ERR_OCR      = 4'd6;
	localparam logic [3:0] ERR_BLKLEN   = 4'd7;
	localparam logic [3:0] ERR_READCMD  = 4'd8;
	localparam logic [3:0] ERR_TOKEN    = 4'd9;
	localparam logic [3:0] ERR_NOTREADY = 4'd10;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_OK   = 2'd2;
	localparam logic [1:0] ST_FAIL = 2'd3;

	localparam logic [2:0] REG_INIT_TO  = 3'd0;
	localparam logic [2:0] REG_TOKEN_TO = 3'd1;
	localparam logic [2:0] REG_BUSY_TO  = 3'd2;
	localparam logic [2:0] REG_ATTEMPTS = 3'd3;
	localparam logic [2:0] REG_POLLS    = 3'd4;
	localparam logic [2:0] REG_GAP      = 3'd5;
	localparam logic [2:0] REG_PREAMBLE = 3'd6;

	// SD command indexes
	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_IF_COND    = 6'd8;
	localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
	localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
	localparam logic [5:0] CMD_OP_COND    = 6'd41;
	localparam logic [5:0] CMD_APP        = 6'd55;
	localparam logic [5:0] CMD_READ_OCR   = 6'd58;

	// Card types
	localparam logic [1:0] CT_NONE  = 2'd0;
	localparam logic [1:0] CT_V1    = 2'd1;
	localparam logic [1:0] CT_V2_SC = 2'd2;
	localparam logic [1:0] CT_V2_HC = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  miso_byte;
		logic [31:0] block_address;
		logic [15:0] block_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       exchange_valid;
		logic       select_level;
		logic       fast_clock;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       data_last;
		logic [1:0] status;
		logic [3:0] error_code;
		logic [1:0] card_type;
		logic       card_ready;
	} out_item_t;

	// Configuration registers as seen by the sequencer
	typedef struct packed {
		logic [15:0] init_to;
		logic [15:0] token_to;
		logic [15:0] busy_to;
		logic [3:0]  attempts;
		logic [7:0]  polls;
		logic [7:0]  gap;
		logic [7:0]  preamble;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic       is_init;
		logic       is_read;
		logic       is_byte;
		logic       is_tick;
		logic [7:0] miso;
		logic [31:0] addr;
		logic [15:0] count;
	} cmd_t;

endpackage

// ===== src/sdsh_fifo.sv =====
// ----------------------------------------------------------------------------
// sdsh_fifo: small synchronous queue
// Register-based FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
module sdsh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sdsh_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	// Store entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(cnt_q > (AW+1)'(DEPTH))) else $error("fifo overflow");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("fifo count mismatch");
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		empty |=> (cnt_q <= (AW+1)'(1))) else $error("fifo read from empty");
`endif
endmodule

// ===== src/sdsh_front.sv =====
// ----------------------------------------------------------------------------
// sdsh_front: input classification
// Decodes the opcode of each accepted item into a command record.
// ----------------------------------------------------------------------------
module sdsh_front (
	input  sdsh_pkg::in_item_t item,
	output sdsh_pkg::cmd_t     cmd
);
	// Classify opcode
	always_comb begin
		cmd         = '0;
		cmd.miso    = item.miso_byte;
		cmd.addr    = item.block_address;
		cmd.count   = item.block_count;
		case (sdsh_pkg::opcode_t'(item.opcode))
			sdsh_pkg::OP_INIT: cmd.is_init = 1'b1;
			sdsh_pkg::OP_READ: cmd.is_read = 1'b1;
			sdsh_pkg::OP_BYTE: cmd.is_byte = 1'b1;
			sdsh_pkg::OP_TICK: cmd.is_tick = 1'b1;
			default:           cmd.is_tick = 1'b0;
		endcase
	end
endmodule

// ===== src/sdsh_back.sv =====
// ----------------------------------------------------------------------------
// sdsh_back: card sequencer
// Runs init and block read phases, one queued command per cycle when go is set.
// ----------------------------------------------------------------------------
module sdsh_back #(
	parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdsh_pkg::cfg_t      cfg,
	input  logic                go,
	input  sdsh_pkg::cmd_t      cmd,
	output sdsh_pkg::out_item_t res
);
	localparam int BCW = $clog2(BLOCK_BYTES) + 1;

	sdsh_pkg::phase_t phase_q, phase_d;
	logic [2:0]  fidx_q, fidx_d;
	logic [5:0]  cidx_q, cidx_d;
	logic [31:0] carg_q, carg_d;
	logic [7:0]  poll_q, poll_d;
	logic [3:0]  retry_q, retry_d;
	logic [15:0] tmo_q, tmo_d, busy_q, busy_d;
	logic [1:0]  trl_q, trl_d;
	logic        v2_q, v2_d, hc_q, hc_d, rdy_q, rdy_d, cs_q, cs_d, fast_q, fast_d;
	logic        init_q, init_d;
	logic [1:0]  type_q, type_d, outc_q, outc_d;
	logic [3:0]  err_q, err_d;
	logic [31:0] blk_q, blk_d;
	logic [15:0] left_q, left_d;
	logic [BCW-1:0] bcnt_q, bcnt_d;
	logic [7:0]  mosi, dbyte;
	logic        xv, dv, dlast;

	function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] ci,
			input logic [31:0] a);
		logic [7:0] r;
		case (k)
			3'd0: r = {2'b01, ci};
			3'd1: r = a[31:24];
			3'd2: r = a[23:16];
			3'd3: r = a[15:8];
			3'd4: r = a[7:0];
			default: r = (ci == sdsh_pkg::CMD_GO_IDLE) ? 8'h95 :
				((ci == sdsh_pkg::CMD_IF_COND) ? 8'h87 : 8'h01);
		endcase
		return r;
	endfunction

	// Next state: one model step per command
	always_comb begin
		logic [7:0]  r;
		logic        done;
		logic [5:0]  ni;
		logic [31:0] na;
		logic        issue, rel, opc;
		logic [3:0]  re;
		phase_d = phase_q; fidx_d = fidx_q; cidx_d = cidx_q; carg_d = carg_q;
		poll_d = poll_q; retry_d = retry_q; tmo_d = tmo_q; busy_d = busy_q;
		trl_d = trl_q; v2_d = v2_q; hc_d = hc_q; rdy_d = rdy_q; cs_d = cs_q;
		fast_d = fast_q; init_d = init_q; type_d = type_q; outc_d = outc_q;
		err_d = err_q; blk_d = blk_q; left_d = left_q; bcnt_d = bcnt_q;
		mosi = 8'hFF; xv = 1'b0; dbyte = 8'h00; dv = 1'b0; dlast = 1'b0;
		r = 8'hFF; done = 1'b0; ni = '0; na = '0; issue = 1'b0; rel = 1'b0;
		opc = 1'b0; re = sdsh_pkg::ERR_NONE;
		if (go) begin
			if (cmd.is_init && phase_q == sdsh_pkg::PH_IDLE) begin
				init_d = 1'b1; err_d = sdsh_pkg::ERR_NONE; rdy_d = 1'b0;
				type_d = sdsh_pkg::CT_NONE;
				fast_d = 1'b0; v2_d = 1'b0; hc_d = 1'b0;
				if (cfg.preamble == 8'd0) begin
					cs_d = 1'b0; retry_d = cfg.attempts;
					if (cfg.attempts == 4'd0) begin rel = 1'b1; re = sdsh_pkg::ERR_IDLE; end
					else begin issue = 1'b1; ni = sdsh_pkg::CMD_GO_IDLE; na = '0; end
				end else begin
					cs_d = 1'b1; phase_d = sdsh_pkg::PH_PRE;
					bcnt_d = BCW'(cfg.preamble); xv = 1'b1;
				end
			end else if (cmd.is_read && phase_q == sdsh_pkg::PH_IDLE) begin
				if (!rdy_q) begin
					outc_d = sdsh_pkg::ST_FAIL; err_d = sdsh_pkg::ERR_NOTREADY;
				end else begin
					init_d = 1'b0; err_d = sdsh_pkg::ERR_NONE; cs_d = 1'b0;
					blk_d = cmd.addr; left_d = cmd.count;
					if (cmd.count == 16'd0) begin rel = 1'b1; end
					else begin
						issue = 1'b1; ni = sdsh_pkg::CMD_READ_BLOCK;
						na = (type_q == sdsh_pkg::CT_V2_HC) ? cmd.addr :
							cmd.addr * 32'(BLOCK_BYTES);
					end
				end
			end else if (cmd.is_tick) begin
				if (tmo_q != 0) tmo_d = tmo_q - 1'b1;
				if (busy_q != 0) busy_d = busy_q - 1'b1;
				if (phase_q == sdsh_pkg::PH_GAP) begin
					if (poll_q != 0) poll_d = poll_q - 1'b1;
					if (poll_q <= 8'd1) begin
						if (tmo_d == 0) begin rel = 1'b1; re = sdsh_pkg::ERR_OPC_TO; end
						else begin issue = 1'b1; ni = sdsh_pkg::CMD_APP; end
					end
				end
			end else if (cmd.is_byte) begin
				case (phase_q)
					sdsh_pkg::PH_PRE: begin
						bcnt_d = bcnt_q - 1'b1;
						if (bcnt_d != 0) xv = 1'b1;
						else begin
							cs_d = 1'b0; retry_d = cfg.attempts;
							if (cfg.attempts == 4'd0) begin
								rel = 1'b1; re = sdsh_pkg::ERR_IDLE;
							end else begin issue = 1'b1; ni = sdsh_pkg::CMD_GO_IDLE; end
						end
					end
					sdsh_pkg::PH_BUSY: begin
						if (cmd.miso == 8'hFF) begin
							phase_d = sdsh_pkg::PH_FRAME; fidx_d = 3'd0; xv = 1'b1;
							mosi = frame_byte(3'd0, cidx_q, carg_q);
						end else if (busy_q == 0) begin done = 1'b1; r = 8'hFF; end
						else xv = 1'b1;
					end
					sdsh_pkg::PH_FRAME: begin
						if (fidx_q < 3'd5) begin
							fidx_d = fidx_q + 1'b1; xv = 1'b1;
							mosi = frame_byte(fidx_d, cidx_q, carg_q);
						end else begin
							fidx_d = 3'd0;
							if (cfg.polls == 8'd0) begin done = 1'b1; r = 8'hFF; end
							else begin
								phase_d = sdsh_pkg::PH_RESP; poll_d = cfg.polls; xv = 1'b1;
							end
						end
					end
					sdsh_pkg::PH_RESP: begin
						if (!cmd.miso[7]) begin done = 1'b1; r = cmd.miso; end
						else begin
							poll_d = poll_q - 1'b1;
							if (poll_d == 0) begin done = 1'b1; r = 8'hFF; end
							else xv = 1'b1;
						end
					end
					sdsh_pkg::PH_R7: begin
						if (trl_q == 2'd2) v2_d = (cmd.miso == 8'h01);
						if (trl_q == 2'd3) begin
							if (v2_q && cmd.miso == 8'hAA) opc = 1'b1;
							else begin v2_d = 1'b0; rel = 1'b1; re = sdsh_pkg::ERR_PATTERN; end
						end else begin trl_d = trl_q + 1'b1; xv = 1'b1; end
					end
					sdsh_pkg::PH_OCR: begin
						if (trl_q == 2'd0) hc_d = cmd.miso[6];
						if (trl_q == 2'd3) begin
							type_d = hc_q ? sdsh_pkg::CT_V2_HC : sdsh_pkg::CT_V2_SC;
							if (hc_q) rel = 1'b1;
							else begin
								issue = 1'b1; ni = sdsh_pkg::CMD_BLOCKLEN;
								na = 32'(BLOCK_BYTES);
							end
						end else begin trl_d = trl_q + 1'b1; xv = 1'b1; end
					end
					sdsh_pkg::PH_TOKEN: begin
						if (cmd.miso == 8'hFF && tmo_q != 0) xv = 1'b1;
						else if (cmd.miso == 8'hFE) begin
							phase_d = sdsh_pkg::PH_DATA; bcnt_d = '0; xv = 1'b1;
						end else begin rel = 1'b1; re = sdsh_pkg::ERR_TOKEN; end
					end
					sdsh_pkg::PH_DATA: begin
						dbyte = cmd.miso; dv = 1'b1;
						dlast = (left_q == 16'd1) && (bcnt_q == BCW'(BLOCK_BYTES-1));
						bcnt_d = bcnt_q + 1'b1;
						if (bcnt_q == BCW'(BLOCK_BYTES-1)) begin
							phase_d = sdsh_pkg::PH_CRC; trl_d = 2'd0; bcnt_d = '0;
						end
						xv = 1'b1;
					end
					sdsh_pkg::PH_CRC: begin
						if (trl_q == 2'd0) begin trl_d = 2'd1; xv = 1'b1; end
						else begin
							trl_d = 2'd0; left_d = left_q - 1'b1; blk_d = blk_q + 1'b1;
							if (left_d == 0) rel = 1'b1;
							else begin
								issue = 1'b1; ni = sdsh_pkg::CMD_READ_BLOCK;
								na = (type_q == sdsh_pkg::CT_V2_HC) ? blk_d :
									blk_d * 32'(BLOCK_BYTES);
							end
						end
					end
					sdsh_pkg::PH_RELEASE: begin
						phase_d = sdsh_pkg::PH_IDLE;
						outc_d = (err_q != 0) ? sdsh_pkg::ST_FAIL : sdsh_pkg::ST_OK;
						if (init_q && err_q == 0) begin fast_d = 1'b1; rdy_d = 1'b1; end
						if (!init_q && err_q != 0) rdy_d = 1'b0;
					end
					default: ;
				endcase
			end
			// Resolve the R1 answer of a finished command
			if (done) begin
				case (cidx_q)
					sdsh_pkg::CMD_GO_IDLE: begin
						if (r == 8'h01) begin
							issue = 1'b1; ni = sdsh_pkg::CMD_IF_COND; na = 32'h1AA;
						end else begin
							retry_d = retry_q - 1'b1;
							if (retry_d != 0) begin issue = 1'b1; ni = sdsh_pkg::CMD_GO_IDLE; end
							else begin rel = 1'b1; re = sdsh_pkg::ERR_IDLE; end
						end
					end
					sdsh_pkg::CMD_IF_COND: begin
						if (r == 8'h01) begin
							phase_d = sdsh_pkg::PH_R7; trl_d = 2'd0; xv = 1'b1;
						end else if (r[2]) begin v2_d = 1'b0; opc = 1'b1; end
						else begin rel = 1'b1; re = sdsh_pkg::ERR_IFCOND; end
					end
					sdsh_pkg::CMD_APP: begin
						if (r > 8'h01) begin rel = 1'b1; re = sdsh_pkg::ERR_OPCOND; end
						else begin
							issue = 1'b1; ni = sdsh_pkg::CMD_OP_COND;
							na = v2_q ? 32'h40000000 : '0;
						end
					end
					sdsh_pkg::CMD_OP_COND: begin
						if (r == 8'h00) begin
							issue = 1'b1;
							if (v2_q) ni = sdsh_pkg::CMD_READ_OCR;
							else begin
								type_d = sdsh_pkg::CT_V1; ni = sdsh_pkg::CMD_BLOCKLEN;
								na = 32'(BLOCK_BYTES);
							end
						end else if (r > 8'h01) begin rel = 1'b1; re = sdsh_pkg::ERR_OPCOND; end
						else begin
							phase_d = sdsh_pkg::PH_GAP; poll_d = cfg.gap;
							if (cfg.gap == 8'd0) begin
								if (tmo_q == 0) begin rel = 1'b1; re = sdsh_pkg::ERR_OPC_TO; end
								else begin issue = 1'b1; ni = sdsh_pkg::CMD_APP; end
							end
						end
					end
					sdsh_pkg::CMD_READ_OCR: begin
						if (r != 0) begin rel = 1'b1; re = sdsh_pkg::ERR_OCR; end
						else begin phase_d = sdsh_pkg::PH_OCR; trl_d = 2'd0; xv = 1'b1; end
					end
					sdsh_pkg::CMD_BLOCKLEN: begin
						rel = 1'b1;
						re = (r != 0) ? sdsh_pkg::ERR_BLKLEN : sdsh_pkg::ERR_NONE;
					end
					sdsh_pkg::CMD_READ_BLOCK: begin
						if (r != 0) begin rel = 1'b1; re = sdsh_pkg::ERR_READCMD; end
						else begin
							tmo_d = cfg.token_to; phase_d = sdsh_pkg::PH_TOKEN; xv = 1'b1;
						end
					end
					default: rel = 1'b1;
				endcase
			end
			// Start the operating-condition loop
			if (opc) begin
				tmo_d = cfg.init_to; issue = 1'b1; ni = sdsh_pkg::CMD_APP; na = '0;
			end
			// Start a command
			if (issue) begin
				cidx_d = ni; carg_d = na; xv = 1'b1;
				if (ni != sdsh_pkg::CMD_GO_IDLE) begin
					phase_d = sdsh_pkg::PH_BUSY; busy_d = cfg.busy_to; mosi = 8'hFF;
				end else begin
					phase_d = sdsh_pkg::PH_FRAME; fidx_d = 3'd0;
					mosi = frame_byte(3'd0, ni, na);
				end
			end
			// Release select and end the request
			if (rel) begin
				err_d = re; cs_d = 1'b1; phase_d = sdsh_pkg::PH_RELEASE;
				xv = 1'b1; mosi = 8'hFF;
			end
		end
		res.mosi_byte      = mosi;
		res.exchange_valid = xv;
		res.select_level   = cs_d;
		res.fast_clock     = fast_d;
		res.data_byte      = dbyte;
		res.data_valid     = dv;
		res.data_last      = dlast;
		res.status         = (phase_d != sdsh_pkg::PH_IDLE) ? sdsh_pkg::ST_BUSY : outc_d;
		res.error_code     = err_d;
		res.card_type      = type_d;
		res.card_ready     = rdy_d;
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdsh_pkg::PH_IDLE; fidx_q <= '0; cidx_q <= '0; carg_q <= '0;
			poll_q <= '0; retry_q <= '0; tmo_q <= '0; busy_q <= '0; trl_q <= '0;
			v2_q <= 1'b0; hc_q <= 1'b0; rdy_q <= 1'b0; cs_q <= 1'b1; fast_q <= 1'b0;
			init_q <= 1'b0; type_q <= sdsh_pkg::CT_NONE; outc_q <= sdsh_pkg::ST_IDLE;
			err_q <= sdsh_pkg::ERR_NONE; blk_q <= '0;
			left_q <= '0; bcnt_q <= '0;
		end else begin
			phase_q <= phase_d; fidx_q <= fidx_d; cidx_q <= cidx_d; carg_q <= carg_d;
			poll_q <= poll_d; retry_q <= retry_d; tmo_q <= tmo_d; busy_q <= busy_d;
			trl_q <= trl_d; v2_q <= v2_d; hc_q <= hc_d; rdy_q <= rdy_d; cs_q <= cs_d;
			fast_q <= fast_d; init_q <= init_d; type_q <= type_d; outc_q <= outc_d;
			err_q <= err_d; blk_q <= blk_d; left_q <= left_d; bcnt_q <= bcnt_d;
		end
	end

`ifndef ASSERT_OFF
	a_data_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.data_valid) |-> (phase_q == sdsh_pkg::PH_DATA)) else $error("stray data");
	a_ready_fast: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> fast_q) else $error("ready without fast clock");
	a_frame_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sdsh_pkg::PH_FRAME) |-> (fidx_q <= 3'd5)) else $error("frame index");
	a_release_cs: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sdsh_pkg::PH_RELEASE) |-> cs_q) else $error("release with select low");
`endif
endmodule

// ===== src/sd_spi_host_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_top: SD card SPI-mode host byte sequencer
// Queue-style input and result ports, plain configuration write port.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result. An item crosses a classifier
// into a two-entry command queue, and the sequencer retires one command per
// cycle into a two-entry result queue unless that queue is full, so a new
// item can be taken every cycle while nothing stalls. The item is registered
// in the command queue and its result in the result queue, from which it
// shows on the result ports until popped. Only a full result queue holds the
// sequencer back; the command queue then fills and raises full.
module sd_spi_host_sequencer_top #(
	parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sdsh_pkg::in_item_t  in_item,
	input  logic                pop,
	output logic                empty,
	output sdsh_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	sdsh_pkg::cmd_t      cls, qcmd;
	sdsh_pkg::out_item_t res;
	sdsh_pkg::cfg_t      cfg_q;
	logic                cq_empty, rq_full, go;

	sdsh_front u_front (.item(in_item), .cmd(cls));

	sdsh_fifo #(.WIDTH($bits(sdsh_pkg::cmd_t))) u_cmdq (
		.clk, .arst_n, .wr_en(push), .wr_data(cls), .full(full),
		.rd_en(go), .rd_data(qcmd), .empty(cq_empty));

	assign go = !cq_empty && !rq_full;

	sdsh_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .go(go), .cmd(qcmd), .res(res));

	sdsh_fifo #(.WIDTH($bits(sdsh_pkg::out_item_t))) u_resq (
		.clk, .arst_n, .wr_en(go), .wr_data(res), .full(rq_full),
		.rd_en(pop), .rd_data(out_item), .empty(empty));

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_to  <= 16'd1000;
			cfg_q.token_to <= 16'd200;
			cfg_q.busy_to  <= 16'd500;
			cfg_q.attempts <= 4'd5;
			cfg_q.polls    <= 8'd10;
			cfg_q.gap      <= 8'd2;
			cfg_q.preamble <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				sdsh_pkg::REG_INIT_TO:  cfg_q.init_to  <= cfg_data;
				sdsh_pkg::REG_TOKEN_TO: cfg_q.token_to <= cfg_data;
				sdsh_pkg::REG_BUSY_TO:  cfg_q.busy_to  <= cfg_data;
				sdsh_pkg::REG_ATTEMPTS: cfg_q.attempts <= cfg_data[3:0];
				sdsh_pkg::REG_POLLS:    cfg_q.polls    <= cfg_data[7:0];
				sdsh_pkg::REG_GAP:      cfg_q.gap      <= cfg_data[7:0];
				sdsh_pkg::REG_PREAMBLE: cfg_q.preamble <= cfg_data[7:0];
				default: ;
			endcase
		end
	end
endmodule
